[src/ffca_pkg.sv]
// Shared types and constants for the first-fit capacity allocator.
// Holds field widths, parameter defaults and the controller/datapath interface.
// No dependencies.
package ffca_pkg;

    localparam int ACTION_W           = 1;
    localparam int BIN_INDEX_W        = 10;
    localparam int AMOUNT_W           = 32;
    localparam int BIN_NUMBER_W       = 11;
    localparam int HOTEL_W            = 11;
    localparam int LEAVES_DEFAULT     = 1024;
    localparam int VALUE_BITS_DEFAULT = 32;

    localparam logic [HOTEL_W-1:0] HOTEL_RESET = 11'd1024;

    localparam logic [ACTION_W-1:0] ACT_LOAD    = 1'b0;
    localparam logic [ACTION_W-1:0] ACT_REQUEST = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_CAPTURE,
        OP_RD_ROOT,
        OP_ROOT_CHK,
        OP_RD_LEFT,
        OP_DESCEND,
        OP_LEAF_WR,
        OP_UP,
        OP_PUBLISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic in_request;
        logic in_load_ok;
        logic is_request;
        logic rdata_fits;
        logic leaf_next;
        logic parent_is_root;
        logic out_free;
    } dp_status_t;

endpackage

[src/ffca_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ffca_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/ffca_ctrl.sv]
// Controller state machine of the first-fit capacity allocator.
// Depends on ffca_pkg for the command and status types.
module ffca_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  ffca_pkg::dp_status_t   status,
    output ffca_pkg::dp_cmd_t      cmd
);

    import ffca_pkg::*;

    typedef enum logic [8:0] {
        ST_CLEAR    = 9'b000000001,
        ST_IDLE     = 9'b000000010,
        ST_ROOT_RD  = 9'b000000100,
        ST_ROOT_CHK = 9'b000001000,
        ST_DESC_RD  = 9'b000010000,
        ST_DESC_CHK = 9'b000100000,
        ST_LEAF_WR  = 9'b001000000,
        ST_UP       = 9'b010000000,
        ST_OUT      = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = OP_CAPTURE;
                    if (status.in_request)
                    begin
                        state_next = ST_ROOT_RD;
                    end
                    else if (status.in_load_ok)
                    begin
                        state_next = ST_LEAF_WR;
                    end
                end
            end
            ST_ROOT_RD:
            begin
                cmd.op     = OP_RD_ROOT;
                state_next = ST_ROOT_CHK;
            end
            ST_ROOT_CHK:
            begin
                cmd.op     = OP_ROOT_CHK;
                state_next = status.rdata_fits ? ST_DESC_RD : ST_OUT;
            end
            ST_DESC_RD:
            begin
                cmd.op     = OP_RD_LEFT;
                state_next = ST_DESC_CHK;
            end
            ST_DESC_CHK:
            begin
                cmd.op     = OP_DESCEND;
                state_next = status.leaf_next ? ST_LEAF_WR : ST_DESC_RD;
            end
            ST_LEAF_WR:
            begin
                cmd.op     = OP_LEAF_WR;
                state_next = ST_UP;
            end
            ST_UP:
            begin
                cmd.op = OP_UP;
                if (status.parent_is_root)
                begin
                    state_next = status.is_request ? ST_OUT : ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_PUBLISH;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

[src/ffca_datapath.sv]
// Datapath of the first-fit capacity allocator: tree memory, walk registers,
// configuration register and result register. Depends on ffca_pkg and ffca_ram.
module ffca_datapath #(
    parameter int LEAVES     = ffca_pkg::LEAVES_DEFAULT,
    parameter int VALUE_BITS = ffca_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ffca_pkg::HOTEL_W-1:0]      cfg_wdata,
    input  logic [ffca_pkg::ACTION_W-1:0]     action,
    input  logic [ffca_pkg::BIN_INDEX_W-1:0]  bin_index,
    input  logic [ffca_pkg::AMOUNT_W-1:0]     amount,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ffca_pkg::BIN_NUMBER_W-1:0] bin_number,
    input  ffca_pkg::dp_cmd_t                 cmd,
    output ffca_pkg::dp_status_t              status
);

    import ffca_pkg::*;

    localparam int LEVELS    = $clog2(LEAVES);
    localparam int ADDR_W    = LEVELS + 1;
    localparam int DEPTH     = 1 << ADDR_W;
    localparam int LEAF_BASE = 1 << LEVELS;
    localparam int CMP_W     = (VALUE_BITS > AMOUNT_W) ? VALUE_BITS : AMOUNT_W;
    localparam int WIDE_W    = (ADDR_W > BIN_NUMBER_W) ? ADDR_W : BIN_NUMBER_W;

    logic [ADDR_W-1:0]       node_reg, node_next;
    logic [VALUE_BITS-1:0]   val_reg, val_next;
    logic [AMOUNT_W-1:0]     want_reg, want_next;
    logic                    req_reg, req_next;
    logic [BIN_NUMBER_W-1:0] res_reg, res_next;
    logic [ADDR_W-1:0]       clr_reg, clr_next;
    logic [HOTEL_W-1:0]      hotel_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [BIN_NUMBER_W-1:0] bin_number_reg, bin_number_next;

    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [VALUE_BITS-1:0]   ram_wdata;
    logic [ADDR_W-1:0]       ram_raddr;
    logic [VALUE_BITS-1:0]   rdata;

    logic [CMP_W-1:0]        want_ext;
    logic [CMP_W-1:0]        rdata_ext;
    logic [CMP_W-1:0]        diff_ext;
    logic [CMP_W-1:0]        amount_ext;
    logic [VALUE_BITS-1:0]   leaf_val;
    logic [VALUE_BITS-1:0]   up_max;
    logic [ADDR_W-1:0]       parent;
    logic [ADDR_W-1:0]       load_addr;
    logic [WIDE_W-1:0]       leaf_number;

    ffca_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_tree_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    assign want_ext    = CMP_W'(want_reg);
    assign rdata_ext   = CMP_W'(rdata);
    assign amount_ext  = CMP_W'(amount);
    assign diff_ext    = CMP_W'(val_reg) - want_ext;
    assign leaf_val    = req_reg ? diff_ext[VALUE_BITS-1:0] : val_reg;
    assign up_max      = (rdata > val_reg) ? rdata : val_reg;
    assign parent      = node_reg >> 1;
    assign load_addr   = ADDR_W'(LEAF_BASE) + ADDR_W'(bin_index);
    assign leaf_number = WIDE_W'(node_reg[LEVELS-1:0]) + WIDE_W'(1);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = node_reg;
        ram_wdata = leaf_val;
        ram_raddr = {node_reg[ADDR_W-2:0], 1'b0};
        case (cmd.op)
            OP_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
            end
            OP_RD_ROOT:
            begin
                ram_raddr = ADDR_W'(1);
            end
            OP_LEAF_WR:
            begin
                ram_we    = 1'b1;
                ram_raddr = node_reg ^ ADDR_W'(1);
            end
            OP_UP:
            begin
                ram_we    = 1'b1;
                ram_waddr = parent;
                ram_wdata = up_max;
                ram_raddr = parent ^ ADDR_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        node_next       = node_reg;
        val_next        = val_reg;
        want_next       = want_reg;
        req_next        = req_reg;
        res_next        = res_reg;
        clr_next        = clr_reg;
        bin_number_next = bin_number_reg;
        out_valid_next  = out_valid_reg & out_stall;
        case (cmd.op)
            OP_CLEAR:
            begin
                clr_next = clr_reg + ADDR_W'(1);
            end
            OP_CAPTURE:
            begin
                node_next = load_addr;
                val_next  = amount_ext[VALUE_BITS-1:0];
                want_next = amount;
                req_next  = (action == ACT_REQUEST);
            end
            OP_ROOT_CHK:
            begin
                node_next = ADDR_W'(1);
                val_next  = rdata;
                res_next  = '0;
            end
            OP_DESCEND:
            begin
                node_next = {node_reg[ADDR_W-2:0], ~status.rdata_fits};
                if (status.rdata_fits)
                begin
                    val_next = rdata;
                end
            end
            OP_LEAF_WR:
            begin
                val_next = leaf_val;
                res_next = leaf_number[BIN_NUMBER_W-1:0];
            end
            OP_UP:
            begin
                node_next = parent;
                val_next  = up_max;
            end
            OP_PUBLISH:
            begin
                out_valid_next  = 1'b1;
                bin_number_next = res_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            hotel_reg     <= HOTEL_RESET;
            out_valid_reg <= 1'b0;
            req_reg       <= 1'b0;
        end
        else
        begin
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            req_reg       <= req_next;
            if (cfg_we)
            begin
                hotel_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg       <= node_next;
        val_reg        <= val_next;
        want_reg       <= want_next;
        res_reg        <= res_next;
        bin_number_reg <= bin_number_next;
    end

    assign status.clear_done     = (clr_reg == {ADDR_W{1'b1}});
    assign status.in_request     = (action == ACT_REQUEST);
    assign status.in_load_ok     = ({1'b0, bin_index} < hotel_reg) && (32'(bin_index) < LEAVES);
    assign status.is_request     = req_reg;
    assign status.rdata_fits     = (rdata_ext >= want_ext);
    assign status.leaf_next      = node_reg[LEVELS-1];
    assign status.parent_is_root = (node_reg[ADDR_W-1:1] == (ADDR_W-1)'(1));
    assign status.out_free       = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign bin_number = bin_number_reg;

endmodule

[src/first_fit_capacity_allocator.sv]
// First-fit capacity allocator over a max segment tree kept in one RAM.
// A fitting request passes the root read and check, the descent, the leaf write and the path refresh
// before out_valid; a request that no bin can take goes from the root check straight to the output.
// A load writes its leaf and refreshes the path; one item is in flight at a time, paced by the single RAM read port.
// Each descent level reads the left child, then compares it; the path refresh writes one parent per step.
// After reset a clearing pass writes all 2**(L+1) tree words, L = clog2(LEAVES), with in_stall high.
// Depends on ffca_pkg, ffca_ctrl, ffca_datapath and ffca_ram.
module first_fit_capacity_allocator #(
    parameter int LEAVES     = ffca_pkg::LEAVES_DEFAULT,
    parameter int VALUE_BITS = ffca_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ffca_pkg::HOTEL_W-1:0]      cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [ffca_pkg::ACTION_W-1:0]     action,
    input  logic [ffca_pkg::BIN_INDEX_W-1:0]  bin_index,
    input  logic [ffca_pkg::AMOUNT_W-1:0]     amount,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ffca_pkg::BIN_NUMBER_W-1:0] bin_number
);

    import ffca_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    ffca_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    ffca_datapath #(
        .LEAVES     (LEAVES),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .action     (action),
        .bin_index  (bin_index),
        .amount     (amount),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .bin_number (bin_number),
        .cmd        (cmd),
        .status     (status)
    );

endmodule

[src/ffca_checker.sv]
// Port-level checks for the first-fit capacity allocator, bound to the top level.
// Depends on first_fit_capacity_allocator and ffca_pkg.
module ffca_checker #(
    parameter int LEAVES = ffca_pkg::LEAVES_DEFAULT
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic [ffca_pkg::ACTION_W-1:0]     action,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [ffca_pkg::BIN_NUMBER_W-1:0] bin_number
);

    import ffca_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(bin_number))
        else $error("Stalled result changed or was dropped.");

    a_bin_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(bin_number) <= LEAVES)
        else $error("Bin number beyond the number of bins.");

    a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (action == ACT_REQUEST) |=> in_stall)
        else $error("Block took a new request while one was in progress.");

    a_req_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (action == ACT_REQUEST) && !out_valid
        |=> !out_valid ##1 !out_valid)
        else $error("Result appeared sooner than the root check allows.");

endmodule

bind first_fit_capacity_allocator ffca_checker #(
    .LEAVES (LEAVES)
) u_ffca_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .bin_number (bin_number)
);
